### rtl/dshot_pkg.sv
// Shared types, constants and register codes for the four-motor DShot frame encoder.
package dshot_pkg;

   localparam int NUM_MOTORS = 4;
   localparam int THR_W      = 12;
   localparam int CODE_W     = 11;
   localparam int WORD_BITS  = 16;
   localparam int CMP_W      = 16;
   localparam int SLOT_W     = 5;
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;

   localparam logic [THR_W-1:0]  CMD_OFFSET = 12'd1953;
   localparam logic [THR_W-1:0]  CMD_MAX    = 12'd4000;
   localparam logic [CODE_W-1:0] CODE_MIN   = 11'd48;

   localparam logic [CMP_W-1:0] ONE_CMP_RESET  = 16'd60;
   localparam logic [CMP_W-1:0] ZERO_CMP_RESET = 16'd30;

   typedef logic [THR_W-1:0]     throttle_type;
   typedef logic [CMP_W-1:0]     cmp_type;
   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [SLOT_W-1:0]    slot_type;

   // Register index, taken from the word address
   typedef enum logic {
      CSR_ONE_BIT  = 1'b0,
      CSR_ZERO_BIT = 1'b1
   } csr_index_type;

   // Control from the slot sequencer to every lane
   typedef struct packed {
      logic load;
      logic shift;
   } lane_ctrl_type;

endpackage

### rtl/dshot_csr.sv
// Configuration registers for the bit compare values, behind an APB-style port.
module dshot_csr
   import dshot_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output cmp_type           one_cmp,
   output cmp_type           zero_cmp
);

   cmp_type       one_cmp_ff, one_cmp_in;
   cmp_type       zero_cmp_ff, zero_cmp_in;
   csr_index_type index;
   logic          wr_en;

   assign csr_pready = 1'b1;
   assign index      = csr_index_type'(csr_paddr[2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   // Decode the write, keep the low half of the data
   always_comb begin
      one_cmp_in  = one_cmp_ff;
      zero_cmp_in = zero_cmp_ff;
      if (wr_en) begin
         unique case (index)
            CSR_ONE_BIT:  one_cmp_in  = csr_pwdata[CMP_W-1:0];
            CSR_ZERO_BIT: zero_cmp_in = csr_pwdata[CMP_W-1:0];
            default:      one_cmp_in  = one_cmp_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         one_cmp_ff  <= ONE_CMP_RESET;
         zero_cmp_ff <= ZERO_CMP_RESET;
      end else begin
         one_cmp_ff  <= one_cmp_in;
         zero_cmp_ff <= zero_cmp_in;
      end
   end

   // Read back, zero extended
   always_comb begin
      unique case (index)
         CSR_ONE_BIT:  csr_prdata = {{(CSR_DW-CMP_W){1'b0}}, one_cmp_ff};
         CSR_ZERO_BIT: csr_prdata = {{(CSR_DW-CMP_W){1'b0}}, zero_cmp_ff};
         default:      csr_prdata = '0;
      endcase
   end

   assign one_cmp  = one_cmp_ff;
   assign zero_cmp = zero_cmp_ff;

endmodule

### rtl/dshot_lane.sv
// One motor lane: encodes the command into a DShot word and shifts it out MSB first.
module dshot_lane
   import dshot_pkg::*;
(
   input  logic          clock,
   input  throttle_type  throttle,
   input  lane_ctrl_type ctrl,
   output logic          word_bit
);

   word_type          word_ff, word_in;
   throttle_type      cmd_sat;
   logic [CODE_W-1:0] code_raw;
   logic [CODE_W-1:0] code;
   logic [CODE_W:0]   code_x2;
   logic [3:0]        csum;
   word_type          word_new;

   // Saturate the command and form the throttle code
   always_comb begin
      cmd_sat = (throttle > CMD_MAX) ? CMD_MAX : throttle;
      if (throttle < CMD_OFFSET) begin
         code_raw = '0;
      end else begin
         code_raw = CODE_W'(cmd_sat - CMD_OFFSET);
      end
      // raise the reserved command codes to the lowest throttle
      if ((code_raw != '0) && (code_raw < CODE_MIN)) begin
         code = CODE_MIN;
      end else begin
         code = code_raw;
      end
      code_x2  = {code, 1'b0};
      csum     = code_x2[3:0] ^ code_x2[7:4] ^ code_x2[11:8];
      word_new = {code, 1'b0, csum};
   end

   // Load a fresh word, or advance one bit per slot
   always_comb begin
      word_in = word_ff;
      if (ctrl.load) begin
         word_in = word_new;
      end else if (ctrl.shift) begin
         word_in = {word_ff[WORD_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_bit = word_ff[WORD_BITS-1];

endmodule

### rtl/dshot_merge.sv
// Slot sequencer: steps through the frame, merges the lane bits into compare values.
module dshot_merge
   import dshot_pkg::*;
#(
   parameter int FRAME_SLOTS = 18
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [NUM_MOTORS-1:0] lane_bits,
   input  cmp_type               one_cmp,
   input  cmp_type               zero_cmp,
   output lane_ctrl_type         lane_ctrl,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output cmp_type               rsp_cmp [NUM_MOTORS],
   output slot_type              rsp_slot,
   output logic                  rsp_tlast
);

   localparam slot_type LastSlot = SLOT_W'(FRAME_SLOTS - 1);
   localparam slot_type WordEnd  = SLOT_W'(WORD_BITS);

   logic     busy_ff, busy_in;
   slot_type slot_ff, slot_in;
   logic     rsp_valid_ff, rsp_valid_in;
   slot_type rsp_slot_ff;
   logic     rsp_last_ff;
   cmp_type  rsp_cmp_ff [NUM_MOTORS];

   logic advance;
   logic final_slot;
   logic accept;

   assign advance    = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign final_slot = (slot_ff == LastSlot);
   assign req_tready = !busy_ff || (advance && final_slot);
   assign accept     = req_tvalid && req_tready;

   assign lane_ctrl.load  = accept;
   assign lane_ctrl.shift = advance;

   // Frame counter and output valid
   always_comb begin
      busy_in      = busy_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         slot_in      = slot_ff + 1'b1;
         rsp_valid_in = 1'b1;
         if (final_slot) begin
            busy_in = 1'b0;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
         slot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Merge the lane bits into the output register; gap slots carry zero
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_slot_ff <= slot_ff;
         rsp_last_ff <= final_slot;
         for (int m = 0; m < NUM_MOTORS; m++) begin
            if (slot_ff < WordEnd) begin
               rsp_cmp_ff[m] <= lane_bits[m] ? one_cmp : zero_cmp;
            end else begin
               rsp_cmp_ff[m] <= '0;
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_cmp    = rsp_cmp_ff;

`ifndef ASSERT_OFF
   a_accept_only_at_frame_end: assert property (@(posedge clock) disable iff (reset)
      accept |-> (!busy_ff || final_slot))
      else $error("item taken while a frame is still in progress");

   a_accept_starts_frame: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy_ff && (slot_ff == '0)))
      else $error("accepted item did not start a frame at slot zero");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_slot_ff <= LastSlot) && (rsp_last_ff == (rsp_slot_ff == LastSlot))))
      else $error("slot number out of range or frame end misplaced");

   a_gap_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_slot_ff >= WordEnd)) |->
         ((rsp_cmp_ff[0] == '0) && (rsp_cmp_ff[1] == '0) &&
          (rsp_cmp_ff[2] == '0) && (rsp_cmp_ff[3] == '0)))
      else $error("gap slot carries a non-zero compare value");
`endif

endmodule

### rtl/dshot_four_motor_frame_encoder_top.sv
// Top level of the four-motor DShot frame encoder: lanes, slot sequencer and registers.
//
//   channel | direction | handshake                 | payload
//   req     | in        | req_tvalid / req_tready   | req_tdata: four 12-bit commands
//   rsp     | out       | rsp_tvalid / rsp_tready   | rsp_tdata: four compares, slot; tlast
//   csr     | in        | csr_psel/penable, pready  | 16-bit compare values at 0x0, 0x4
//
// Each item yields FRAME_SLOTS transfers, one per cycle while rsp_tready is high; the slot
// counter feeding the output register sets that number.
// The next item is taken in the cycle the last slot enters the output register.
// Encoding happens in the acceptance cycle; lane registers, then output register, follow.
// Reset (synchronous) empties the frame and loads compare values 60 and 30.
// A stall on rsp holds the output register and stops the lane shift registers shifting.
module dshot_four_motor_frame_encoder_top
   import dshot_pkg::*;
#(
   parameter int FRAME_SLOTS = 18
) (
   input  logic              clock,
   input  logic              reset,
   // [11:0] motor_1_throttle, [23:12] motor_2_throttle,
   // [35:24] motor_3_throttle, [47:36] motor_4_throttle
   input  logic [47:0]       req_tdata,
   input  logic              req_tvalid,
   output logic              req_tready,
   // [15:0] slot_motor_1, [31:16] slot_motor_2, [47:32] slot_motor_3,
   // [63:48] slot_motor_4, [68:64] slot_number, [71:69] zero
   output logic [71:0]       rsp_tdata,
   output logic              rsp_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   cmp_type               one_cmp;
   cmp_type               zero_cmp;
   lane_ctrl_type         lane_ctrl;
   logic [NUM_MOTORS-1:0] lane_bits;
   cmp_type               rsp_cmp [NUM_MOTORS];
   slot_type              rsp_slot;

   dshot_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .one_cmp     (one_cmp),
      .zero_cmp    (zero_cmp)
   );

   // One encoder lane per motor
   for (genvar m = 0; m < NUM_MOTORS; m++) begin : g_lane
      dshot_lane u_lane (
         .clock    (clock),
         .throttle (req_tdata[m*THR_W +: THR_W]),
         .ctrl     (lane_ctrl),
         .word_bit (lane_bits[m])
      );
   end

   dshot_merge #(
      .FRAME_SLOTS (FRAME_SLOTS)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .lane_bits  (lane_bits),
      .one_cmp    (one_cmp),
      .zero_cmp   (zero_cmp),
      .lane_ctrl  (lane_ctrl),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_cmp    (rsp_cmp),
      .rsp_slot   (rsp_slot),
      .rsp_tlast  (rsp_tlast)
   );

   // Pack the result transfer
   assign rsp_tdata = {3'b000, rsp_slot, rsp_cmp[3], rsp_cmp[2], rsp_cmp[1], rsp_cmp[0]};

endmodule
